### design/nggp_pkg.sv
// ============================================================================
// nggp_pkg
// Shared types, constants and reset text for the GGA/VTG sentence parser.
// ============================================================================
`default_nettype none

package nggp_pkg;

    // characters kept per text field
    localparam int FIELD_CHARS = 16;
    localparam int IDX_W       = $clog2(FIELD_CHARS);
    localparam int LEN_W       = $clog2(FIELD_CHARS + 1);
    localparam int SLOT_W      = 2;
    localparam int SLOTS       = 4;
    // text RAM: {slot, bank, index}
    localparam int MEM_AW      = SLOT_W + 1 + IDX_W;
    localparam int MEM_DEPTH   = 1 << MEM_AW;

    localparam logic [2:0] HDR_DONE  = 3'd7;
    localparam logic [4:0] FIELD_MAX = 5'd31;

    localparam logic [3:0] LOCK_PERIOD_RST  = 4'd2;
    localparam logic [3:0] NOFIX_PERIOD_RST = 4'd10;

    // command codes
    localparam logic [1:0] CMD_CHAR    = 2'd0;
    localparam logic [1:0] CMD_CLR_POS = 2'd1;
    localparam logic [1:0] CMD_CLR_VEL = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    // configuration register indexes
    localparam logic CFG_LOCK_PERIOD  = 1'b0;
    localparam logic CFG_NOFIX_PERIOD = 1'b1;

    // text slots
    localparam logic [SLOT_W-1:0] SLOT_TIME  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAT   = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_LON   = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_SPEED = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GGA  = 2'd1,
        KIND_VTG  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_in;
        logic       line_end;
        logic [1:0] read_field;
        logic [3:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_char;
        logic [3:0] fix_quality;
        logic [6:0] satellites_used;
        logic       position_updated;
        logic       velocity_updated;
        logic       led_on;
        logic       sentence_done;
    } t_out_item;

    typedef struct packed {
        logic [3:0] lock_period;
        logic [3:0] nofix_period;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // per-item result from the parser, read data joins it after the RAM
    typedef struct packed {
        logic [3:0] fix_quality;
        logic [6:0] satellites_used;
        logic       position_updated;
        logic       velocity_updated;
        logic       led_on;
        logic       sentence_done;
        logic       rd_hit;
        logic       rd_init;
        logic [7:0] init_char;
    } t_res;

    function automatic logic [LEN_W-1:0] init_len(input logic [SLOT_W-1:0] slot);
        int n;
        case (slot)
            SLOT_TIME:  n = 10;
            SLOT_LAT:   n = 11;
            SLOT_LON:   n = 11;
            default:    n = 7;
        endcase
        if (n > FIELD_CHARS) n = FIELD_CHARS;
        return LEN_W'(n);
    endfunction

    // reset text, padded to 11 characters; padding is never read
    function automatic logic [7:0] init_char(input logic [SLOT_W-1:0] slot,
                                             input logic [IDX_W-1:0]  idx);
        logic [87:0] s;
        int          k;
        case (slot)
            SLOT_TIME:  s = "000000.0000";
            SLOT_LAT:   s = "00000.0000N";
            SLOT_LON:   s = "00000.0000W";
            default:    s = "0000.000000";
        endcase
        k = 10 - int'(idx);
        if (k < 0) return 8'd0;
        return s[8*k +: 8];
    endfunction

endpackage

`default_nettype wire

### design/nggp_text_mem.sv
// ============================================================================
// nggp_text_mem
// Text RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module nggp_text_mem (
    input  wire logic                     i_clk,
    input  wire nggp_pkg::t_mem_wr        i_wr,
    input  wire logic                     i_rd_en,
    input  wire logic [nggp_pkg::MEM_AW-1:0] i_rd_addr,
    output logic [7:0]                    o_rd_data
);

    logic [7:0] r_mem [nggp_pkg::MEM_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/nggp_parser.sv
// ============================================================================
// nggp_parser
// Per-character sentence parser: header match, field staging, commit,
// line finish, flags and blink counter. Text goes to the RAM as it arrives.
// ============================================================================
`default_nettype none

module nggp_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire nggp_pkg::t_in_item          i_item,
    input  wire nggp_pkg::t_cfg              i_cfg,
    output nggp_pkg::t_mem_wr                o_wr,
    output logic [nggp_pkg::MEM_AW-1:0]      o_rd_addr,
    output nggp_pkg::t_res                   o_res
);

    localparam int LW = nggp_pkg::LEN_W;
    localparam int IW = nggp_pkg::IDX_W;

    logic [2:0]          r_hdr_pos,   n_hdr_pos;
    nggp_pkg::t_kind     r_kind,      n_kind;
    logic [4:0]          r_field_num, n_field_num;
    logic [LW-1:0]       r_stage_cnt, n_stage_cnt;
    logic [7:0]          r_acc,       n_acc;
    logic                r_stopped,   n_stopped;
    logic [3:0]          r_quality,   n_quality;
    logic [6:0]          r_sats,      n_sats;
    logic                r_pos_flag,  n_pos_flag;
    logic                r_vel_flag,  n_vel_flag;
    logic [3:0]          r_blink,     n_blink;
    logic                r_led,       n_led;
    logic [LW-1:0]       r_len  [nggp_pkg::SLOTS];
    logic [LW-1:0]       n_len  [nggp_pkg::SLOTS];
    logic [nggp_pkg::SLOTS-1:0] r_bank, n_bank;
    logic [nggp_pkg::SLOTS-1:0] r_init, n_init;

    // header
    logic                hdr_ok;
    nggp_pkg::t_kind     hdr_kind;
    // field target
    logic                       tgt_valid;
    logic                       tgt_append;
    logic [nggp_pkg::SLOT_W-1:0] tgt_slot;
    logic [LW:0]                wr_pos;
    logic [LW:0]                app_sum;
    logic [7:0]                 dig;
    logic [11:0]                mac;
    logic                       done;
    logic [3:0]                 blink_inc;
    logic [3:0]                 target;
    logic                       led_t;
    logic [LW-1:0]              ridx;

    wire logic [7:0] c = i_item.char_in;

    always_comb begin
        hdr_ok   = 1'b0;
        hdr_kind = r_kind;
        case (r_hdr_pos)
            3'd0: hdr_ok = (c == "$");
            3'd1: hdr_ok = (c == "G");
            3'd2: hdr_ok = (c == "P");
            3'd3: begin
                hdr_ok   = (c == "G") || (c == "V");
                hdr_kind = (c == "V") ? nggp_pkg::KIND_VTG : nggp_pkg::KIND_GGA;
            end
            3'd4: hdr_ok = (r_kind == nggp_pkg::KIND_GGA) ? (c == "G") : (c == "T");
            3'd5: hdr_ok = (r_kind == nggp_pkg::KIND_GGA) ? (c == "A") : (c == "G");
            default: hdr_ok = (c == ",");
        endcase
    end

    // where the current field's text lands
    always_comb begin
        tgt_valid  = 1'b0;
        tgt_append = 1'b0;
        tgt_slot   = nggp_pkg::SLOT_TIME;
        if (r_kind == nggp_pkg::KIND_GGA) begin
            case (r_field_num)
                5'd0: begin tgt_valid = 1'b1; tgt_slot = nggp_pkg::SLOT_TIME; end
                5'd1: begin tgt_valid = 1'b1; tgt_slot = nggp_pkg::SLOT_LAT; end
                5'd2: begin
                    tgt_valid = 1'b1; tgt_slot = nggp_pkg::SLOT_LAT; tgt_append = 1'b1;
                end
                5'd3: begin tgt_valid = 1'b1; tgt_slot = nggp_pkg::SLOT_LON; end
                5'd4: begin
                    tgt_valid = 1'b1; tgt_slot = nggp_pkg::SLOT_LON; tgt_append = 1'b1;
                end
                default: tgt_valid = 1'b0;
            endcase
        end else if (r_kind == nggp_pkg::KIND_VTG && r_field_num == 5'd6) begin
            tgt_valid = 1'b1;
            tgt_slot  = nggp_pkg::SLOT_SPEED;
        end
    end

    assign app_sum = {1'b0, r_len[tgt_slot]} + {1'b0, r_stage_cnt};
    assign wr_pos  = tgt_append ? app_sum : {1'b0, r_stage_cnt};
    assign dig     = c - 8'h30;
    assign mac     = {4'd0, r_acc} * 12'd10 + {8'd0, dig[3:0]};
    assign ridx    = LW'(i_item.read_index);

    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_kind      = r_kind;
        n_field_num = r_field_num;
        n_stage_cnt = r_stage_cnt;
        n_acc       = r_acc;
        n_stopped   = r_stopped;
        n_quality   = r_quality;
        n_sats      = r_sats;
        n_pos_flag  = r_pos_flag;
        n_vel_flag  = r_vel_flag;
        n_blink     = r_blink;
        n_led       = r_led;
        n_len       = r_len;
        n_bank      = r_bank;
        n_init      = r_init;
        o_wr        = '0;
        done        = 1'b0;
        blink_inc   = r_blink + 4'd1;
        target      = 4'd0;
        led_t       = r_led;

        if (i_item.command == nggp_pkg::CMD_CHAR) begin
            if (r_hdr_pos < nggp_pkg::HDR_DONE) begin
                if (hdr_ok) begin
                    n_hdr_pos = r_hdr_pos + 3'd1;
                    n_kind    = hdr_kind;
                end else begin
                    n_hdr_pos = nggp_pkg::HDR_DONE;
                    n_kind    = nggp_pkg::KIND_NONE;
                end
            end else if (r_kind != nggp_pkg::KIND_NONE) begin
                if (c == ",") begin
                    // commit the field
                    if (tgt_valid) begin
                        if (tgt_append) begin
                            n_len[tgt_slot] = (app_sum > (LW+1)'(nggp_pkg::FIELD_CHARS)) ?
                                LW'(nggp_pkg::FIELD_CHARS) : app_sum[LW-1:0];
                        end else begin
                            n_len[tgt_slot]  = r_stage_cnt;
                            n_bank[tgt_slot] = ~r_bank[tgt_slot];
                            n_init[tgt_slot] = 1'b0;
                        end
                    end else if (r_kind == nggp_pkg::KIND_GGA && r_field_num == 5'd5) begin
                        n_quality = (r_acc > 8'd15) ? 4'd15 : r_acc[3:0];
                    end else if (r_kind == nggp_pkg::KIND_GGA && r_field_num == 5'd6) begin
                        n_sats = (r_acc > 8'd127) ? 7'd127 : r_acc[6:0];
                    end
                    if (r_field_num < nggp_pkg::FIELD_MAX) n_field_num = r_field_num + 5'd1;
                    n_stage_cnt = '0;
                    n_acc       = '0;
                    n_stopped   = 1'b0;
                end else begin
                    if (r_stage_cnt < LW'(nggp_pkg::FIELD_CHARS)) begin
                        n_stage_cnt = r_stage_cnt + LW'(1);
                    end
                    if (tgt_valid && wr_pos < (LW+1)'(nggp_pkg::FIELD_CHARS)) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = {tgt_slot,
                                     tgt_append ? r_bank[tgt_slot] : ~r_bank[tgt_slot],
                                     wr_pos[IW-1:0]};
                        o_wr.data = c;
                    end
                    if (!r_stopped && c >= "0" && c <= "9") begin
                        n_acc = (mac > 12'd255) ? 8'd255 : mac[7:0];
                    end else begin
                        n_stopped = 1'b1;
                    end
                end
            end

            if (i_item.line_end) begin
                done = (n_hdr_pos == nggp_pkg::HDR_DONE) && (n_kind != nggp_pkg::KIND_NONE);
                if (done) begin
                    if (n_kind == nggp_pkg::KIND_GGA) begin
                        if (n_quality != 4'd0) n_pos_flag = 1'b1;
                        if (r_blink == 4'd0) led_t = 1'b0;
                        target = (n_quality == 4'd0) ? i_cfg.nofix_period
                                                     : i_cfg.lock_period;
                        if (blink_inc >= target) begin
                            n_led   = 1'b1;
                            n_blink = 4'd0;
                        end else begin
                            n_led   = led_t;
                            n_blink = blink_inc;
                        end
                    end else begin
                        if (n_quality != 4'd0) n_vel_flag = 1'b1;
                    end
                end
                n_hdr_pos   = '0;
                n_kind      = nggp_pkg::KIND_NONE;
                n_field_num = '0;
                n_stage_cnt = '0;
                n_acc       = '0;
                n_stopped   = 1'b0;
            end
        end else if (i_item.command == nggp_pkg::CMD_CLR_POS) begin
            n_pos_flag = 1'b0;
        end else if (i_item.command == nggp_pkg::CMD_CLR_VEL) begin
            n_vel_flag = 1'b0;
        end

        if (!i_step) o_wr.en = 1'b0;
    end

    always_comb begin
        o_rd_addr              = {i_item.read_field, r_bank[i_item.read_field],
                                  IW'(i_item.read_index)};
        o_res.fix_quality      = n_quality;
        o_res.satellites_used  = n_sats;
        o_res.position_updated = n_pos_flag;
        o_res.velocity_updated = n_vel_flag;
        o_res.led_on           = n_led;
        o_res.sentence_done    = done;
        o_res.rd_hit           = (i_item.command == nggp_pkg::CMD_READ) &&
                                 (ridx < r_len[i_item.read_field]) &&
                                 (ridx < LW'(nggp_pkg::FIELD_CHARS));
        o_res.rd_init          = r_init[i_item.read_field];
        o_res.init_char        = nggp_pkg::init_char(i_item.read_field,
                                                     IW'(i_item.read_index));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos   <= '0;
            r_kind      <= nggp_pkg::KIND_NONE;
            r_field_num <= '0;
            r_stage_cnt <= '0;
            r_acc       <= '0;
            r_stopped   <= 1'b0;
            r_quality   <= '0;
            r_sats      <= '0;
            r_pos_flag  <= 1'b0;
            r_vel_flag  <= 1'b0;
            r_blink     <= '0;
            r_led       <= 1'b0;
            for (int s = 0; s < nggp_pkg::SLOTS; s++) begin
                r_len[s] <= nggp_pkg::init_len(nggp_pkg::SLOT_W'(s));
            end
            r_bank      <= '0;
            r_init      <= '1;
        end else if (i_step) begin
            r_hdr_pos   <= n_hdr_pos;
            r_kind      <= n_kind;
            r_field_num <= n_field_num;
            r_stage_cnt <= n_stage_cnt;
            r_acc       <= n_acc;
            r_stopped   <= n_stopped;
            r_quality   <= n_quality;
            r_sats      <= n_sats;
            r_pos_flag  <= n_pos_flag;
            r_vel_flag  <= n_vel_flag;
            r_blink     <= n_blink;
            r_led       <= n_led;
            r_len       <= n_len;
            r_bank      <= n_bank;
            r_init      <= n_init;
        end
    end

endmodule

`default_nettype wire

### design/nmea_gga_vtg_parser_core.sv
// ============================================================================
// nmea_gga_vtg_parser_core
// NMEA 0183 GGA/VTG sentence parser, one character or command per transaction.
// ============================================================================
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------
//  input    | in        | i_valid / o_ready             | i_data (t_in_item)
//  result   | out       | o_valid / i_ready             | o_data (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  One transaction per cycle sustained while results are taken. An accepted item
//  is held in the input register; the parser step and the text RAM read then
//  land it in the result register, which raises o_valid.
//  The text RAM (one write, one registered read port) sets that read stage.
//  Reset is synchronous, active low; no clearing pass: reset text is served
//  from constants until a slot is first committed. A stalled result holds the
//  pipe; the input register still takes one item while the result waits.
//
// Text fields are written into the RAM as characters arrive. Each slot has two
// banks: a fresh field fills the idle bank and a commit (the comma after the
// field) flips the bank and sets the length, so an unfinished field never
// shows. Hemisphere appends go into the live bank past its length, hidden
// until the commit extends the length.
// ============================================================================
`default_nettype none

module nmea_gga_vtg_parser_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input items
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire nggp_pkg::t_in_item   i_data,
    // results
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output nggp_pkg::t_out_item       o_data,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [3:0]           i_cfg_data
);

    logic                       r_s1_valid;
    nggp_pkg::t_in_item         r_s1_item;
    logic                       r_out_valid;
    nggp_pkg::t_res             r_out_res;
    nggp_pkg::t_cfg             r_cfg;

    logic                       w_adv;
    nggp_pkg::t_mem_wr          w_wr;
    logic [nggp_pkg::MEM_AW-1:0] w_rd_addr;
    logic [7:0]                 w_rd_data;
    nggp_pkg::t_res             w_res;

    // stage 1 moves on when the result register is free or being emptied
    assign w_adv       = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_s1_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_s1_valid <= i_valid;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_s1_item <= i_data;
        if (w_adv)              r_out_res <= w_res;
    end

    // blink periods
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lock_period  <= nggp_pkg::LOCK_PERIOD_RST;
            r_cfg.nofix_period <= nggp_pkg::NOFIX_PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nggp_pkg::CFG_LOCK_PERIOD:  r_cfg.lock_period  <= i_cfg_data;
                nggp_pkg::CFG_NOFIX_PERIOD: r_cfg.nofix_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nggp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_item    (r_s1_item),
        .i_cfg     (r_cfg),
        .o_wr      (w_wr),
        .o_rd_addr (w_rd_addr),
        .o_res     (w_res)
    );

    nggp_text_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // read character: zero past the length, reset text until first commit
    always_comb begin
        o_valid                 = r_out_valid;
        o_data.read_char        = !r_out_res.rd_hit ? 8'd0 :
                                  r_out_res.rd_init ? r_out_res.init_char : w_rd_data;
        o_data.fix_quality      = r_out_res.fix_quality;
        o_data.satellites_used  = r_out_res.satellites_used;
        o_data.position_updated = r_out_res.position_updated;
        o_data.velocity_updated = r_out_res.velocity_updated;
        o_data.led_on           = r_out_res.led_on;
        o_data.sentence_done    = r_out_res.sentence_done;
    end

endmodule

`default_nettype wire

### sim/tb_nmea_gga_vtg_parser_core.sv
// ============================================================================
// tb_nmea_gga_vtg_parser_core
// Self-checking bench for the GGA/VTG sentence parser. Directed sentences hit
// header rejection, truncation, saturation and field-count limits. Random
// traffic follows under three stall patterns and several blink settings.
// Every result is compared field by field against an in-bench parser model.
// ============================================================================

module tb_nmea_gga_vtg_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nggp_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no transaction on any channel
    localparam int PHASE_ITEMS = 160;   // parsed items per random phase
    localparam int PRINT_CAP   = 200;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    t_in_item   i_data      = '0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    t_out_item  o_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = 1'b0;
    logic [3:0] i_cfg_data  = 4'd0;

    nmea_gga_vtg_parser_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------------
    string            reset_text [SLOTS] = '{"000000.000", "00000.0000N",
                                             "00000.0000W", "0000.00"};
    logic [7:0]       stored_text [SLOTS][FIELD_CHARS];
    logic [LEN_W-1:0] stored_len  [SLOTS];
    logic [7:0]       stage_chars [FIELD_CHARS];
    logic [LEN_W-1:0] stage_len;
    logic [2:0]       hdr_pos;
    t_kind            sentence;
    logic [4:0]       field_idx;
    logic [7:0]       digit_acc;
    logic             digits_done;
    logic [3:0]       fix_q;
    logic [6:0]       sat_count;
    logic             pos_upd;
    logic             vel_upd;
    logic [3:0]       blink_cnt;
    logic             led_lvl;
    logic [3:0]       lock_period  = LOCK_PERIOD_RST;
    logic [3:0]       nofix_period = NOFIX_PERIOD_RST;
    bit               item_ignored;

    t_out_item  pending_results[$];
    logic [7:0] line_chars[$];
    int         mismatch_count = 0;
    int         parsed_items   = 0;
    int         send_idle_pct  = 19;
    int         recv_idle_pct  = 70;

    function automatic void clear_field();
        stage_len   = '0;
        digit_acc   = '0;
        digits_done = 1'b0;
    endfunction

    function automatic void restart_line();
        hdr_pos   = '0;
        sentence  = KIND_NONE;
        field_idx = '0;
        clear_field();
    endfunction

    // copy staged chars into a slot; append continues past the current text
    function automatic void store_text(input logic [SLOT_W-1:0] slot, input bit append);
        int len;
        len = append ? int'(stored_len[slot]) : 0;
        for (int k = 0; k < int'(stage_len) && len < FIELD_CHARS; k++) begin
            stored_text[slot][len] = stage_chars[k];
            len++;
        end
        stored_len[slot] = LEN_W'(len);
    endfunction

    // one transaction through the model; returns the result it should produce
    function automatic t_out_item parser_step(input t_in_item item);
        t_out_item  res;
        logic [7:0] c;
        logic       hdr_ok;
        int         acc;
        res          = '0;
        c            = item.char_in;
        item_ignored = 1'b0;
        case (item.command)
            CMD_CHAR: begin
                if (hdr_pos != HDR_DONE) begin
                    case (hdr_pos)
                        3'd0: hdr_ok = (c == "$");
                        3'd1: hdr_ok = (c == "G");
                        3'd2: hdr_ok = (c == "P");
                        3'd3: begin
                            hdr_ok   = (c == "G") || (c == "V");
                            sentence = (c == "V") ? KIND_VTG : KIND_GGA;
                        end
                        3'd4: hdr_ok = (sentence == KIND_GGA) ? (c == "G") : (c == "T");
                        3'd5: hdr_ok = (sentence == KIND_GGA) ? (c == "A") : (c == "G");
                        default: hdr_ok = (c == ",");
                    endcase
                    if (hdr_ok) begin
                        hdr_pos = hdr_pos + 3'd1;
                    end else begin
                        hdr_pos  = HDR_DONE;
                        sentence = KIND_NONE;
                    end
                end else if (sentence != KIND_NONE) begin
                    if (c == ",") begin
                        // the comma commits the field just gathered
                        if (sentence == KIND_GGA) begin
                            case (field_idx)
                                5'd0: store_text(SLOT_TIME, 1'b0);
                                5'd1: store_text(SLOT_LAT, 1'b0);
                                5'd2: store_text(SLOT_LAT, 1'b1);
                                5'd3: store_text(SLOT_LON, 1'b0);
                                5'd4: store_text(SLOT_LON, 1'b1);
                                5'd5: fix_q = (digit_acc > 8'd15) ? 4'd15 : digit_acc[3:0];
                                5'd6: sat_count = (digit_acc > 8'd127) ? 7'd127 : digit_acc[6:0];
                                default: ;
                            endcase
                        end else if (field_idx == 5'd6) begin
                            store_text(SLOT_SPEED, 1'b0);
                        end
                        if (field_idx != FIELD_MAX) field_idx = field_idx + 5'd1;
                        clear_field();
                    end else begin
                        if (stage_len < FIELD_CHARS) begin
                            stage_chars[stage_len] = c;
                            stage_len = stage_len + 1'b1;
                        end
                        if (!digits_done && c >= "0" && c <= "9") begin
                            acc       = int'(digit_acc) * 10 + int'(c - "0");
                            digit_acc = (acc > 255) ? 8'd255 : 8'(acc);
                        end else begin
                            digits_done = 1'b1;
                        end
                    end
                end else if (!item.line_end) begin
                    item_ignored = 1'b1;
                end
                if (item.line_end) begin
                    if (hdr_pos == HDR_DONE && sentence != KIND_NONE) begin
                        if (sentence == KIND_GGA) begin
                            if (fix_q != 4'd0) pos_upd = 1'b1;
                            if (blink_cnt == 4'd0) led_lvl = 1'b0;
                            blink_cnt = blink_cnt + 4'd1;
                            if (blink_cnt >= ((fix_q == 4'd0) ? nofix_period : lock_period)) begin
                                led_lvl   = 1'b1;
                                blink_cnt = 4'd0;
                            end
                        end else if (fix_q != 4'd0) begin
                            vel_upd = 1'b1;
                        end
                        res.sentence_done = 1'b1;
                    end
                    restart_line();
                end
            end
            CMD_CLR_POS: pos_upd = 1'b0;
            CMD_CLR_VEL: vel_upd = 1'b0;
            default: begin
                if (item.read_index < stored_len[item.read_field])
                    res.read_char = stored_text[item.read_field][item.read_index];
            end
        endcase
        res.fix_quality      = fix_q;
        res.satellites_used  = sat_count;
        res.position_updated = pos_upd;
        res.velocity_updated = vel_upd;
        res.led_on           = led_lvl;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random backpressure, compare against oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // keep the log bounded when the design is badly broken
        if (mismatch_count <= PRINT_CAP) $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s: got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("read_char",        o_data.read_char,        want.read_char);
                check_field("fix_quality",      o_data.fix_quality,      want.fix_quality);
                check_field("satellites_used",  o_data.satellites_used,  want.satellites_used);
                check_field("position_updated", o_data.position_updated, want.position_updated);
                check_field("velocity_updated", o_data.velocity_updated, want.velocity_updated);
                check_field("led_on",           o_data.led_on,           want.led_on);
                check_field("sentence_done",    o_data.sentence_done,    want.sentence_done);
            end
        end
    end

    // hang detector: any accepted transaction restarts the count
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(parser_step(item));
        if (!item_ignored) parsed_items++;
    endtask

    // non-character command; unused fields carry random junk
    task automatic send_command(input logic [1:0] cmd, input logic [1:0] fld,
                                input logic [3:0] idx);
        t_in_item item;
        item.command    = cmd;
        item.char_in    = 8'($urandom);
        item.line_end   = 1'($urandom);
        item.read_field = fld;
        item.read_index = idx;
        send_item(item);
    endtask

    task automatic send_line(input bit with_strays);
        t_in_item   item;
        logic [1:0] cmd;
        for (int k = 0; k < line_chars.size(); k++) begin
            if (with_strays && $urandom_range(99) < 4) begin
                case ($urandom_range(3))
                    0:       cmd = CMD_CLR_POS;
                    1:       cmd = CMD_CLR_VEL;
                    default: cmd = CMD_READ;
                endcase
                send_command(cmd, 2'($urandom), 4'($urandom));
            end
            item.command    = CMD_CHAR;
            item.char_in    = line_chars[k];
            item.line_end   = (k == line_chars.size() - 1);
            item.read_field = 2'($urandom);
            item.read_index = 4'($urandom);
            send_item(item);
        end
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) line_chars.push_back(s[k]);
    endtask

    task automatic send_text(input string s);
        line_chars.delete();
        add_text(s);
        send_line(1'b0);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_blink_periods(input logic [3:0] lock, input logic [3:0] nofix);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LOCK_PERIOD;
        i_cfg_data  <= lock;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        lock_period = lock;
        i_cfg_index <= CFG_NOFIX_PERIOD;
        i_cfg_data  <= nofix;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        nofix_period = nofix;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random sentence building
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_field_char();
        logic [7:0] c;
        int         r;
        r = $urandom_range(99);
        if (r < 70) return "0" + 8'($urandom_range(9));
        if (r < 80) return ".";
        if (r < 90) return "A" + 8'($urandom_range(25));
        do c = 8'($urandom_range(255)); while (c == ",");
        return c;
    endfunction

    task automatic add_rand_field();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 85)      n = $urandom_range(6);
        else if (r < 95) n = $urandom_range(12, 7);
        else             n = $urandom_range(24, 13);
        repeat (n) line_chars.push_back(rand_field_char());
    endtask

    task automatic add_hemisphere(input bit east_west);
        logic [7:0] c;
        if ($urandom_range(99) < 80) begin
            if (east_west) c = $urandom_range(1) ? "E" : "W";
            else           c = $urandom_range(1) ? "N" : "S";
            line_chars.push_back(c);
        end else begin
            add_rand_field();
        end
    endtask

    task automatic add_number_field(input bit is_quality);
        int r;
        r = $urandom_range(99);
        if (is_quality && r < 30)  add_text("0");
        else if (r < 70)           add_text($sformatf("%0d", $urandom_range(is_quality ? 9 : 24)));
        else if (r < 85)           add_text($sformatf("%0d", $urandom_range(999)));
        else if (r < 92)           add_text(r[0] ? "-1" : " 5");
        else                       add_rand_field();
    endtask

    task automatic add_sentence(input bit vtg);
        int extra;
        if (vtg) begin
            add_text("$GPVTG,");
            repeat (7) begin
                add_rand_field();
                add_text(",");
            end
        end else begin
            add_text("$GPGGA,");
            add_rand_field();    add_text(",");
            add_rand_field();    add_text(",");
            add_hemisphere(0);   add_text(",");
            add_rand_field();    add_text(",");
            add_hemisphere(1);   add_text(",");
            add_number_field(1); add_text(",");
            add_number_field(0); add_text(",");
        end
        // occasionally run the field counter past its ceiling
        extra = ($urandom_range(99) < 92) ? $urandom_range(4) : $urandom_range(40, 26);
        repeat (extra) begin
            add_rand_field();
            add_text(",");
        end
        add_rand_field();    // trailing field has no comma, never committed
    endtask

    task automatic send_random_line();
        int         r;
        int         n;
        logic [1:0] fld;
        logic [3:0] idx;
        r = $urandom_range(99);
        line_chars.delete();
        if (r < 85) begin
            add_sentence(r >= 45 && r < 75 ? 1'b1 : 1'b0);
            if (r >= 75)    // corrupt one header character
                line_chars[$urandom_range(6)] = 8'($urandom_range(255));
        end else if (r < 90) begin
            repeat ($urandom_range(20, 1)) line_chars.push_back(8'($urandom_range(255)));
        end else begin
            // line cut short, often inside the header
            add_sentence(1'($urandom));
            n = ($urandom_range(99) < 40) ? $urandom_range(7, 1)
                                          : $urandom_range(line_chars.size() - 1, 1);
            while (line_chars.size() > n) void'(line_chars.pop_back());
        end
        send_line(1'b1);
        repeat ($urandom_range(3)) begin
            fld = 2'($urandom);
            n   = int'(stored_len[fld]);
            if (n > 15) n = 15;
            idx = ($urandom_range(99) < 85) ? 4'($urandom_range(n)) : 4'($urandom);
            send_command(CMD_READ, fld, idx);
        end
    endtask

    task automatic run_random_phase(input logic [3:0] lock, input logic [3:0] nofix);
        wait_results_drained();
        write_blink_periods(lock, nofix);
        parsed_items = 0;
        while (parsed_items < PHASE_ITEMS) send_random_line();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        send_command(CMD_READ, SLOT_TIME, 4'd0);
        send_command(CMD_READ, SLOT_TIME, 4'd9);
        send_command(CMD_READ, SLOT_TIME, 4'd10);
        send_command(CMD_READ, SLOT_LAT, 4'd10);
        send_command(CMD_READ, SLOT_LAT, 4'd11);
        send_command(CMD_READ, SLOT_LON, 4'd10);
        send_command(CMD_READ, SLOT_SPEED, 4'd6);
        send_command(CMD_READ, SLOT_SPEED, 4'd7);
        send_command(CMD_READ, SLOT_SPEED, 4'd15);
    endtask

    task automatic test_gga_fix();
        send_text("$GPGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        for (int k = 0; k < 16; k++) send_command(CMD_READ, SLOT_LAT, 4'(k));
        send_command(CMD_READ, SLOT_LON, 4'd10);
        send_command(CMD_READ, SLOT_TIME, 4'd8);
    endtask

    task automatic test_vtg_speed();
        send_text("$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K*48");
        for (int k = 0; k < 6; k++) send_command(CMD_READ, SLOT_SPEED, 4'(k));
    endtask

    task automatic test_clear_flags();
        send_command(CMD_CLR_POS, 2'd3, 4'd15);
        send_command(CMD_CLR_VEL, 2'd0, 4'd0);
    endtask

    task automatic test_rejected_lines();
        send_text("$GPGSA,A,3,04,,*3D");
        send_text("$GPGG");              // ends inside the header
        send_text("$GPVTA,1,2,");
        send_text("$gpgga,1,");
        send_text("GPGGA,1,2,");
        send_text("$GPGGA");             // ends just before the comma
        send_text("$GPGGA,");            // accepted, no fields at all
        send_text(",");
    endtask

    task automatic test_text_and_number_limits();
        // long time and latitude truncate, hemisphere append finds no room,
        // quality and satellite counts saturate
        send_text("$GPGGA,0123456789012345678,0000.000000000000,S,1,W,300,999,x");
        send_command(CMD_READ, SLOT_TIME, 4'd15);
        send_command(CMD_READ, SLOT_LAT, 4'd15);
        send_command(CMD_READ, SLOT_LON, 4'd0);
        send_command(CMD_READ, SLOT_LON, 4'd1);
        send_command(CMD_READ, SLOT_LON, 4'd2);
        // empty text, signed and spaced numbers read as zero
        send_text("$GPGGA,,,,,,-1, 7,");
        send_command(CMD_READ, SLOT_TIME, 4'd0);
        send_text("$GPVTG,,,,,,,5.5,");
        // speed as the last field of the line is never committed
        send_text("$GPVTG,1,2,3,4,5,6,77");
        send_command(CMD_READ, SLOT_SPEED, 4'd0);
        send_command(CMD_READ, SLOT_SPEED, 4'd2);
    endtask

    task automatic test_field_count_limit();
        // a wrapping field counter would overwrite the time with "9"
        line_chars.delete();
        add_text("$GPGGA,111,,,,,,,");
        repeat (35) add_text("9,");
        add_text("*00");
        send_line(1'b0);
        send_command(CMD_READ, SLOT_TIME, 4'd0);
        send_command(CMD_READ, SLOT_TIME, 4'd3);
    endtask

    task automatic test_random_slow_sink();
        send_idle_pct = 19;
        recv_idle_pct = 70;
        run_random_phase(4'd1, 4'd15);
        run_random_phase(4'd15, 4'd1);
    endtask

    task automatic test_random_slow_source();
        send_idle_pct = 70;
        recv_idle_pct = 19;
        run_random_phase(4'd0, 4'd7);    // lock period 0: LED on for every GGA line with a fix
        run_random_phase(4'd3, 4'd0);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(4'd15, 4'd15);
        run_random_phase(4'd1, 4'd1);
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            for (int k = 0; k < FIELD_CHARS; k++)
                stored_text[s][k] = (k < reset_text[s].len()) ? reset_text[s][k] : 8'd0;
            stored_len[s] = LEN_W'(reset_text[s].len());
        end
        for (int k = 0; k < FIELD_CHARS; k++) stage_chars[k] = 8'd0;
        restart_line();
        fix_q     = '0;
        sat_count = '0;
        pos_upd   = 1'b0;
        vel_upd   = 1'b0;
        blink_cnt = '0;
        led_lvl   = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_gga_fix();
        test_vtg_speed();
        test_clear_flags();
        test_rejected_lines();
        test_text_and_number_limits();
        test_field_count_limit();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();

        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
